>>> rtl/rtp_pkg.sv
// Shared types, constants and elaboration-time functions of the rectangular to polar converter.
// Computes the CORDIC arctangent table entries in Q60 from truncated integer series.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rtp_pkg;

  localparam int unsigned CORDIC_W = 64;
  localparam int unsigned NUM_ITER = 60;
  localparam int unsigned Q_FRAC   = 60;
  localparam int unsigned NORM_MSB = 59;
  localparam int unsigned SHIFT_W  = 6;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic origin;
    logic ax_zero;
    logic ay_zero;
  } pt_flags_t;

  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] atan_recip(logic [63:0] n);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    p   = udiv64(64'd1 << Q_FRAC, n);
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != '0) begin
        term = udiv64(p, 64'(2 * k + 1));
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
        if (n >= (64'd1 << 31)) begin
          p = '0;
        end else begin
          p = udiv64(p, n * n);
        end
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] atan_q60(int unsigned i);
    logic [63:0] res;
    if (i == 0) begin
      res = atan_recip(64'd2) + atan_recip(64'd3);
    end else begin
      res = atan_recip(64'd1 << i);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> rtl/rectangular_to_polar_convert_top.sv
// Top level of the rectangular to polar converter: front end, CORDIC, square root,
// result rounding, output register and skid stage.
// Depends on rtp_pkg, rtp_prep, rtp_cordic and rtp_sqrt.
//
//   port group  dir  tdata (lsb first)                      tuser
//   s_axis      in   x_coord[W-1:0], y_coord[W-1:0]         -
//   m_axis      out  radius[W-1:0], angle[F+1:0]            origin_point
//
// One point per cycle sustained while no skid word is held; the path runs through
// 3 front-end stages, 60 CORDIC iterations and 1 output stage.
// Reset clears valid bits only, the skid valid bit among them.
// A result refused downstream moves into the skid stage; the pipeline then
// freezes and s_axis_tready drops until the skid word is taken.
`timescale 1ns / 1ps
`default_nettype none
module rectangular_to_polar_convert_top #(
  parameter int unsigned COORD_WIDTH     = 16,
  parameter int unsigned ANGLE_FRAC_BITS = 13
) (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  input  wire logic                                           s_axis_tvalid,
  output logic                                                s_axis_tready,
  // x_coord, y_coord
  input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0]             s_axis_tdata,
  output logic                                                m_axis_tvalid,
  input  wire logic                                           m_axis_tready,
  // radius, angle
  output logic [((COORD_WIDTH+ANGLE_FRAC_BITS+2+7)/8)*8-1:0]  m_axis_tdata,
  // origin_point
  output logic                                                m_axis_tuser
);

  localparam int unsigned W      = COORD_WIDTH;
  localparam int unsigned F      = ANGLE_FRAC_BITS;
  localparam int unsigned AngW   = F + 2;
  localparam int unsigned MagW   = F + 1;
  localparam int unsigned OutW   = ((W + AngW + 7) / 8) * 8;
  localparam int unsigned QF     = rtp_pkg::Q_FRAC;
  localparam logic [63:0] RndC   = 64'd1 << (QF - 1 - F);
  localparam logic [63:0] HalfPiRnd = (2 * rtp_pkg::atan_q60(0)) + RndC;
  localparam logic [MagW-1:0] HalfPiMag = HalfPiRnd[QF:QF-F];
  localparam logic [AngW-1:0] HalfPiAng = AngW'(HalfPiMag);

  logic en;

  logic                          pre_v;
  rtp_pkg::pt_flags_t            pre_f;
  logic [2*W-1:0]                pre_sum;
  logic [rtp_pkg::CORDIC_W-1:0]  pre_x, pre_y;

  logic                          cor_v;
  rtp_pkg::pt_flags_t            cor_f;
  logic [rtp_pkg::CORDIC_W-1:0]  cor_z;

  logic [W-1:0]                  sq_root;
  logic [W+1:0]                  sq_rem;

  logic [63:0]                   z_rnd;
  logic [MagW-1:0]               cmag, mag;
  logic                          neg;
  logic [AngW-1:0]               angle_d;
  logic [W-1:0]                  radius_d;

  logic                          out_v_q;
  logic [W-1:0]                  out_radius_q;
  logic [AngW-1:0]               out_angle_q;
  logic                          out_origin_q;

  logic                          skid_v_q;
  logic [W-1:0]                  skid_radius_q;
  logic [AngW-1:0]               skid_angle_q;
  logic                          skid_origin_q;

  logic [W-1:0]                  out_radius;
  logic [AngW-1:0]               out_angle;
  logic                          out_origin;

  assign en            = ~skid_v_q;
  assign s_axis_tready = en;

  rtp_prep #(
    .COORD_WIDTH (W)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .x_i     (s_axis_tdata[W-1:0]),
    .y_i     (s_axis_tdata[2*W-1:W]),
    .valid_o (pre_v),
    .flags_o (pre_f),
    .sum_o   (pre_sum),
    .x0_o    (pre_x),
    .y0_o    (pre_y)
  );

  rtp_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pre_v),
    .flags_i (pre_f),
    .x_i     (pre_x),
    .y_i     (pre_y),
    .valid_o (cor_v),
    .flags_o (cor_f),
    .z_o     (cor_z)
  );

  rtp_sqrt #(
    .COORD_WIDTH (W),
    .PAD_STAGES  (rtp_pkg::NUM_ITER - W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sum_i  (pre_sum),
    .root_o (sq_root),
    .rem_o  (sq_rem)
  );

  assign z_rnd = cor_z + RndC;
  assign cmag  = cor_z[63] ? '0 : z_rnd[QF:QF-F];

  always_comb begin
    if (cor_f.origin || cor_f.ay_zero) begin
      mag = '0;
      neg = 1'b0;
    end else if (cor_f.ax_zero) begin
      mag = HalfPiMag;
      neg = cor_f.yneg;
    end else begin
      mag = cmag;
      neg = cor_f.xneg ^ cor_f.yneg;
    end
  end

  assign angle_d  = neg ? (AngW'(0) - AngW'(mag)) : AngW'(mag);
  assign radius_d = (sq_rem > {2'b00, sq_root}) ? (sq_root + W'(1)) : sq_root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (en) begin
        out_v_q <= cor_v;
      end
      if (en && out_v_q && !m_axis_tready) begin
        skid_v_q <= 1'b1;
      end else if (skid_v_q && m_axis_tready) begin
        skid_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_radius_q  <= radius_d;
      out_angle_q   <= angle_d;
      out_origin_q  <= cor_f.origin;
      skid_radius_q <= out_radius_q;
      skid_angle_q  <= out_angle_q;
      skid_origin_q <= out_origin_q;
    end
  end

  assign out_radius = skid_v_q ? skid_radius_q : out_radius_q;
  assign out_angle  = skid_v_q ? skid_angle_q  : out_angle_q;
  assign out_origin = skid_v_q ? skid_origin_q : out_origin_q;

  assign m_axis_tvalid = skid_v_q | out_v_q;
  assign m_axis_tdata  = OutW'({out_angle, out_radius});
  assign m_axis_tuser  = out_origin;

  a_radius_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((out_radius == '0) == out_origin))
    else $error("zero radius and origin flag disagree");

  a_origin_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_origin |-> (out_angle == '0))
    else $error("origin word carries nonzero angle");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(out_angle) <= $signed(HalfPiAng)) &&
                      ($signed(out_angle) >= -$signed(HalfPiAng)))
    else $error("angle outside half-pi range");

  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !m_axis_tready |=> skid_v_q && $stable(skid_radius_q) &&
                                   $stable(skid_angle_q) && $stable(skid_origin_q))
    else $error("skid word lost or changed while stalled");

endmodule
`default_nettype wire

>>> rtl/rtp_prep.sv
// Front end: magnitudes, special-case flags, squares, leading-one search and normalizing shift.
// Three register stages; all stages advance together on en_i.
// Depends on rtp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtp_prep #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic [COORD_WIDTH-1:0]     x_i,
  input  wire logic [COORD_WIDTH-1:0]     y_i,
  output logic                            valid_o,
  output rtp_pkg::pt_flags_t              flags_o,
  output logic [2*COORD_WIDTH-1:0]        sum_o,
  output logic [rtp_pkg::CORDIC_W-1:0]    x0_o,
  output logic [rtp_pkg::CORDIC_W-1:0]    y0_o
);

  localparam int unsigned MsbW = $clog2(COORD_WIDTH);

  // stage 1
  logic                   v1_q;
  logic [COORD_WIDTH-1:0] ax1_q, ay1_q, ax1_d, ay1_d;
  logic                   xn1_q, yn1_q;
  // stage 2
  logic                        v2_q;
  logic [COORD_WIDTH-1:0]      ax2_q, ay2_q;
  logic [2*COORD_WIDTH-1:0]    sqx2_q, sqy2_q, sqx2_d, sqy2_d;
  logic [rtp_pkg::SHIFT_W-1:0] sh2_q, sh2_d;
  logic [COORD_WIDTH-1:0]      or1;
  logic [MsbW-1:0]             msb1;
  rtp_pkg::pt_flags_t          fl2_q, fl2_d;
  // stage 3
  logic                          v3_q;
  logic [2*COORD_WIDTH-1:0]      sum3_q, sum3_d;
  logic [rtp_pkg::CORDIC_W-1:0]  x3_q, y3_q, x3_d, y3_d;
  rtp_pkg::pt_flags_t            fl3_q;

  assign ax1_d = x_i[COORD_WIDTH-1] ? (COORD_WIDTH'(0) - x_i) : x_i;
  assign ay1_d = y_i[COORD_WIDTH-1] ? (COORD_WIDTH'(0) - y_i) : y_i;

  assign or1 = ax1_q | ay1_q;

  always_comb begin
    msb1 = '0;
    for (int b = 0; b < COORD_WIDTH; b++) begin
      if (or1[b]) begin
        msb1 = MsbW'(b);
      end
    end
  end

  assign sh2_d  = rtp_pkg::SHIFT_W'(rtp_pkg::NORM_MSB - int'(msb1));
  assign sqx2_d = ax1_q * ax1_q;
  assign sqy2_d = ay1_q * ay1_q;

  always_comb begin
    fl2_d.xneg    = xn1_q;
    fl2_d.yneg    = yn1_q;
    fl2_d.ax_zero = (ax1_q == '0);
    fl2_d.ay_zero = (ay1_q == '0);
    fl2_d.origin  = (ax1_q == '0) && (ay1_q == '0);
  end

  assign sum3_d = sqx2_q + sqy2_q;
  assign x3_d   = rtp_pkg::CORDIC_W'(ax2_q) << sh2_q;
  assign y3_d   = rtp_pkg::CORDIC_W'(ay2_q) << sh2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax1_q  <= ax1_d;
      ay1_q  <= ay1_d;
      xn1_q  <= x_i[COORD_WIDTH-1];
      yn1_q  <= y_i[COORD_WIDTH-1];
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      sqx2_q <= sqx2_d;
      sqy2_q <= sqy2_d;
      sh2_q  <= sh2_d;
      fl2_q  <= fl2_d;
      sum3_q <= sum3_d;
      x3_q   <= x3_d;
      y3_q   <= y3_d;
      fl3_q  <= fl2_q;
    end
  end

  assign valid_o = v3_q;
  assign flags_o = fl3_q;
  assign sum_o   = sum3_q;
  assign x0_o    = x3_q;
  assign y0_o    = y3_q;

endmodule
`default_nettype wire

>>> rtl/rtp_cordic.sv
// Vectoring CORDIC, one iteration per register stage, 64-bit datapath.
// Carries the valid bit and point flags alongside the angle accumulator.
// Depends on rtp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtp_cordic (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire rtp_pkg::pt_flags_t           flags_i,
  input  wire logic [rtp_pkg::CORDIC_W-1:0] x_i,
  input  wire logic [rtp_pkg::CORDIC_W-1:0] y_i,
  output logic                              valid_o,
  output rtp_pkg::pt_flags_t                flags_o,
  output logic [rtp_pkg::CORDIC_W-1:0]      z_o
);

  localparam int unsigned N = rtp_pkg::NUM_ITER;

  logic                          v_q  [1:N];
  rtp_pkg::pt_flags_t            f_q  [1:N];
  logic [rtp_pkg::CORDIC_W-1:0]  x_q  [1:N];
  logic [rtp_pkg::CORDIC_W-1:0]  y_q  [1:N];
  logic [rtp_pkg::CORDIC_W-1:0]  z_q  [1:N];

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic [rtp_pkg::CORDIC_W-1:0] AtanC = rtp_pkg::atan_q60(i);

    logic                         v_in;
    rtp_pkg::pt_flags_t           f_in;
    logic [rtp_pkg::CORDIC_W-1:0] x_in, y_in, z_in, dx, dy, x_d, y_d, z_d;

    if (i == 0) begin : g_first
      assign v_in = valid_i;
      assign f_in = flags_i;
      assign x_in = x_i;
      assign y_in = y_i;
      assign z_in = '0;
    end else begin : g_rest
      assign v_in = v_q[i];
      assign f_in = f_q[i];
      assign x_in = x_q[i];
      assign y_in = y_q[i];
      assign z_in = z_q[i];
    end

    assign dx = rtp_pkg::CORDIC_W'($signed(y_in) >>> i);
    assign dy = rtp_pkg::CORDIC_W'($signed(x_in) >>> i);

    always_comb begin
      if (y_in[rtp_pkg::CORDIC_W-1]) begin
        x_d = x_in - dx;
        y_d = y_in + dy;
        z_d = z_in - AtanC;
      end else begin
        x_d = x_in + dx;
        y_d = y_in - dy;
        z_d = z_in + AtanC;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        f_q[i+1] <= f_in;
        x_q[i+1] <= x_d;
        y_q[i+1] <= y_d;
        z_q[i+1] <= z_d;
      end
    end
  end

  assign valid_o = v_q[N];
  assign flags_o = f_q[N];
  assign z_o     = z_q[N];

endmodule
`default_nettype wire

>>> rtl/rtp_sqrt.sv
// Pipelined integer square root, one root bit per stage, with remainder out.
// A plain delay line after the root stages matches the CORDIC latency.
// Depends on no package.
`timescale 1ns / 1ps
`default_nettype none
module rtp_sqrt #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned PAD_STAGES  = 44
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic [2*COORD_WIDTH-1:0] sum_i,
  output logic [COORD_WIDTH-1:0]        root_o,
  output logic [COORD_WIDTH+1:0]        rem_o
);

  localparam int unsigned W = COORD_WIDTH;

  logic [2*W-1:0] s_q  [1:W];
  logic [W+1:0]   r_q  [1:W];
  logic [W-1:0]   q_q  [1:W];
  logic [W+1:0]   pr_q [1:PAD_STAGES];
  logic [W-1:0]   pq_q [1:PAD_STAGES];

  for (genvar j = 0; j < W; j++) begin : g_digit
    localparam int unsigned Bp = W - 1 - j;

    logic [2*W-1:0] s_in;
    logic [W+1:0]   r_in, r_d;
    logic [W-1:0]   q_in, q_d;
    logic [W+3:0]   acc, trial;

    if (j == 0) begin : g_first
      assign s_in = sum_i;
      assign r_in = '0;
      assign q_in = '0;
    end else begin : g_rest
      assign s_in = s_q[j];
      assign r_in = r_q[j];
      assign q_in = q_q[j];
    end

    assign acc   = {r_in, s_in[2*Bp+1 -: 2]};
    assign trial = {2'b00, q_in, 2'b01};

    always_comb begin
      if (acc >= trial) begin
        r_d = (W+2)'(acc - trial);
        q_d = {q_in[W-2:0], 1'b1};
      end else begin
        r_d = acc[W+1:0];
        q_d = {q_in[W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[j+1] <= s_in;
        r_q[j+1] <= r_d;
        q_q[j+1] <= q_d;
      end
    end
  end

  for (genvar k = 0; k < PAD_STAGES; k++) begin : g_pad
    logic [W+1:0] r_in;
    logic [W-1:0] q_in;

    if (k == 0) begin : g_first
      assign r_in = r_q[W];
      assign q_in = q_q[W];
    end else begin : g_rest
      assign r_in = pr_q[k];
      assign q_in = pq_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pr_q[k+1] <= r_in;
        pq_q[k+1] <= q_in;
      end
    end
  end

  assign root_o = pq_q[PAD_STAGES];
  assign rem_o  = pr_q[PAD_STAGES];

endmodule
`default_nettype wire

>>> tb/rectangular_to_polar_convert_top_tb.sv
// Self-checking bench for rectangular_to_polar_convert_top: streams points, predicts
// radius, angle and origin flag with a local CORDIC model and compares every result word.
// Depends only on rectangular_to_polar_convert_top.
`timescale 1ns / 1ps
module rectangular_to_polar_convert_top_tb;

  localparam int unsigned CW    = 16;
  localparam int unsigned FB    = 13;
  localparam int unsigned ITERS = 60;

  typedef struct packed {
    logic [CW-1:0]        radius;
    logic signed [FB+1:0] angle;
    logic                 origin_point;
  } polar_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  logic [63:0] atan_q60_tab [ITERS];
  logic [31:0] pending_points [$];
  polar_t      expected_polar [$];
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  logic        idle_on = 1'b1;
  int          in_gap = 0;
  int          out_stall = 0;
  int          errors = 0;

  rectangular_to_polar_convert_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // atan(1/n) in Q60, alternating series with truncated terms
  function automatic logic [63:0] atan_series(logic [63:0] n);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] k;
    p   = (64'd1 << 60) / n;
    sum = '0;
    k   = '0;
    while (p != '0) begin
      if (k[0]) sum = sum - p / (2 * k + 1);
      else sum = sum + p / (2 * k + 1);
      if (n >= (64'd1 << 31)) p = '0;
      else p = p / (n * n);
      k++;
    end
    return sum;
  endfunction

  function automatic polar_t polar_of(logic [31:0] point);
    logic [CW-1:0] xv, yv;
    logic          xneg, yneg, neg;
    logic [63:0]   ax, ay, s, q, cand, mag;
    longint        cx, cy, acc, dx, dy;
    polar_t        res;
    xv   = point[15:0];
    yv   = point[31:16];
    xneg = xv[CW-1];
    yneg = yv[CW-1];
    ax   = xneg ? 64'(CW'(-xv)) : 64'(xv);
    ay   = yneg ? 64'(CW'(-yv)) : 64'(yv);
    if (xneg && ax == 0) ax = 64'd1 << (CW - 1);
    if (yneg && ay == 0) ay = 64'd1 << (CW - 1);
    res = '0;
    if (ax == 0 && ay == 0) begin
      res.origin_point = 1'b1;
      return res;
    end
    s = ax * ax + ay * ay;
    q = '0;
    for (int b = 17; b >= 0; b--) begin
      cand = q | (64'd1 << b);
      if (cand * cand <= s) q = cand;
    end
    res.radius = CW'((s > q * q + q) ? q + 1 : q);
    mag = '0;
    neg = 1'b0;
    if (ay == 0) begin
      mag = '0;
    end else if (ax == 0) begin
      mag = (2 * atan_q60_tab[0] + (64'd1 << (59 - FB))) >> (60 - FB);
      neg = yneg;
    end else begin
      cx  = ax;
      cy  = ay;
      acc = 0;
      while (cx < (64'sd1 <<< 59) && cy < (64'sd1 <<< 59)) begin
        cx = cx <<< 1;
        cy = cy <<< 1;
      end
      for (int i = 0; i < ITERS; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy < 0) begin
          cx  = cx - dx;
          cy  = cy + dy;
          acc = acc - longint'(atan_q60_tab[i]);
        end else begin
          cx  = cx + dx;
          cy  = cy - dy;
          acc = acc + longint'(atan_q60_tab[i]);
        end
      end
      if (acc < 0) acc = 0;
      mag = (64'(acc) + (64'd1 << (59 - FB))) >> (60 - FB);
      neg = (xneg != yneg);
    end
    res.angle = (FB + 2)'(neg ? -mag : mag);
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    errors++;
  endtask

  // predict each accepted point; input below: hold until accepted, then idle and advance
  always @(posedge clk_i) begin
    in_fire  <= s_axis_tvalid && s_axis_tready;
    out_fire <= m_axis_tvalid && m_axis_tready;
    if (s_axis_tvalid && s_axis_tready) expected_polar.push_back(polar_of(s_axis_tdata));
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (in_fire) in_gap = idle_on ? $urandom_range(0, 5) : 0;
      if (in_gap != 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_points.size() != 0) begin
        s_axis_tdata  <= pending_points.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side: stall per word
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) out_stall = idle_on ? $urandom_range(0, 5) : 0;
      if (out_stall != 0) begin
        out_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    polar_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_polar.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata, '0);
      end else begin
        want = expected_polar.pop_front();
        if (m_axis_tdata[15:0] !== want.radius)
          report_mismatch("radius", 32'(m_axis_tdata[15:0]), 32'(want.radius));
        if (m_axis_tdata[30:16] !== want.angle)
          report_mismatch("angle", 32'(m_axis_tdata[30:16]), {17'd0, want.angle});
        if (m_axis_tdata[31] !== 1'b0)
          report_mismatch("pad bit", 32'(m_axis_tdata[31]), '0);
        if (m_axis_tuser !== want.origin_point)
          report_mismatch("origin_point", 32'(m_axis_tuser), 32'(want.origin_point));
      end
    end
  end

  function automatic logic [15:0] rand_coord();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = 16'h8000;
      2:       v = 16'h7fff;
      3, 4:    v = 16'($signed($urandom_range(0, 127)) - 64);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  initial begin
    logic [15:0] dir_x [25] = '{16'd0, 16'd0, 16'hffff, 16'd0, 16'd0, 16'd1, 16'hffff,
                                 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                                 16'd1, 16'hffff, 16'd1, 16'hffff, 16'd3, 16'hfffd,
                                 16'h7fff, 16'd1, 16'h8000, 16'd12345, 16'hffff, 16'd100};
    logic [15:0] dir_y [25] = '{16'd0, 16'd1, 16'd0, 16'h7fff, 16'h8000, 16'd0, 16'hffff,
                                 16'd0, 16'd0, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                                 16'd1, 16'd1, 16'hffff, 16'd0, 16'd4, 16'hfffc,
                                 16'd1, 16'h7fff, 16'd1, 16'ha460, 16'h8000, 16'hff9c};
    atan_q60_tab[0] = atan_series(64'd2) + atan_series(64'd3);
    for (int i = 1; i < ITERS; i++) atan_q60_tab[i] = atan_series(64'd1 << i);

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < 25; i++) pending_points.push_back({dir_y[i], dir_x[i]});

    for (int chunk = 0; chunk < 10; chunk++) begin
      // drain everything before the random part and once in the middle of it
      if (chunk == 0 || chunk == 5) begin
        while (pending_points.size() != 0 || s_axis_tvalid || expected_polar.size() != 0)
          @(negedge clk_i);
      end
      idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 50; i++) pending_points.push_back({rand_coord(), rand_coord()});
      while (pending_points.size() > 8) @(negedge clk_i);
    end

    while (pending_points.size() != 0 || s_axis_tvalid || expected_polar.size() != 0)
      @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    if (errors == 0 && expected_polar.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/rtp_pkg.sv
rtl/rtp_prep.sv
rtl/rtp_cordic.sv
rtl/rtp_sqrt.sv
rtl/rectangular_to_polar_convert_top.sv
tb/rectangular_to_polar_convert_top_tb.sv
